// ===== hw/rtl/implicit_list_next_fit_allocator_unit_macros.svh =====
`ifndef IMPLICIT_LIST_NEXT_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define IMPLICIT_LIST_NEXT_FIT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ILNFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ILNFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ilnfa_pkg.sv =====
`default_nettype none
package ilnfa_pkg;

  localparam int HEAP_WORDS_DEF = 16384;
  localparam int CHUNK_W        = 17;
  localparam logic [CHUNK_W-1:0] CHUNK_RST = 17'd4096;
  localparam logic [31:0] MIN_BLOCK    = 32'd16;
  localparam logic [31:0] PROLOGUE_PLD = 32'd8;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;
  localparam logic [1:0] ST_NOINIT  = 2'd3;

endpackage
`default_nettype wire

// ===== hw/rtl/ilnfa_ram.sv =====
`default_nettype none
module ilnfa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/implicit_list_next_fit_allocator_unit.sv =====
// Boundary-tag heap manager with next-fit placement over a tag memory.
// Input channel (in_valid/in_stall): one transaction carries an operation
// (init, allocate, free), a request size and a block address. Result channel
// (out_valid/out_stall): exactly one transaction per input with a status and
// a payload address. cfg_wr_en/cfg_wr_data set the heap growth chunk size;
// write it only while the block is idle.
// Each operation runs on a small sequencer that drives the single-port tag
// RAM, one read or one write per cycle. Init writes the prologue and epilogue
// tags, then grows the heap; free clears the used bit in the block's tags,
// then merges it with free neighbours; allocate walks the headers, writes
// the tags, splits a large block and grows the heap when none fits; a request
// rejected at accept skips the RAM. The input is taken again in the cycle
// after the result is loaded, so the walk length sets the throughput.
// The block takes a new input only when the sequencer is idle; a finished
// result sits in the output register while the next input is taken. If the
// receiver stalls, the output holds and the next result waits in the final
// state until the register frees up.
// Reset (rst_n low, synchronous) clears the heap state, chunk size goes to
// 4096; the tag RAM is not cleared.
`default_nettype none
module implicit_list_next_fit_allocator_unit #(
  parameter int HEAP_WORDS = ilnfa_pkg::HEAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_address
);
  import ilnfa_pkg::*;

  localparam int IW    = $clog2(HEAP_WORDS);
  localparam int TAG_W = $clog2(HEAP_WORDS * 4) + 1;
  localparam int SW    = $clog2(HEAP_WORDS + 2);
  localparam logic [31:0] HW32 = 32'(HEAP_WORDS);
  localparam logic [31:0] HB32 = 32'(HEAP_WORDS * 4);

  localparam logic [4:0] S_IDLE = 5'd0,  S_INIT0 = 5'd1,  S_INIT1 = 5'd2,  S_INIT2 = 5'd3,
                         S_INIT3 = 5'd4, S_GROW = 5'd5,   S_GW1 = 5'd6,    S_GW2 = 5'd7,
                         S_M0 = 5'd8,    S_M1 = 5'd9,     S_M2 = 5'd10,    S_M3 = 5'd11,
                         S_M4 = 5'd12,   S_M5 = 5'd13,    S_M6 = 5'd14,    S_MW1 = 5'd15,
                         S_MW2 = 5'd16,  S_MDONE = 5'd17, S_SC0 = 5'd18,   S_SC1 = 5'd19,
                         S_SET = 5'd20,  S_SW1 = 5'd21,   S_SW2 = 5'd22,   S_SW3 = 5'd23,
                         S_SW4 = 5'd24,  S_F0 = 5'd25,    S_F1 = 5'd26,    S_F2 = 5'd27,
                         S_FIN = 5'd28;

  logic [4:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        addr_r, addr_nxt;
  logic [31:0]        brk_r, brk_nxt, rover_r, rover_nxt;
  logic               init_r, init_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [31:0]        b_r, b_nxt, bs_r, bs_nxt, pb_r, pb_nxt, phs_r, phs_nxt;
  logic               pa_r, pa_nxt, na_r, na_nxt, split_r, split_nxt;
  logic [31:0]        ns_r, ns_nxt, nf_r, nf_nxt, msz_r, msz_nxt;
  logic [31:0]        wa1_r, wa1_nxt, wa2_r, wa2_nxt;
  logic [31:0]        need_r, need_nxt, have_r, have_nxt, grow_r, grow_nxt;
  logic [SW-1:0]      steps_r, steps_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [15:0]        res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [15:0]        out_addr_r, out_addr_nxt;
  logic               rd_oor_r;

  logic [31:0]      acc_addr, acc_wd, rd32, rd_sz, eff_chunk, gsz, sz_sum, d_sz;
  logic             acc_we, acc_oor, accept;
  logic [TAG_W-1:0] mem_rdata;

  assign rd32      = rd_oor_r ? 32'd0 : 32'(mem_rdata);
  assign rd_sz     = rd32 & ~32'd7;
  assign eff_chunk = (chunk_r < CHUNK_W'(8)) ? 32'd8 : 32'(chunk_r);
  assign gsz       = (((grow_r >> 2) + 32'd1) & ~32'd1) << 2;
  assign d_sz      = have_r - need_r;
  assign acc_oor   = (acc_addr >> 2) >= HW32;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);

  ilnfa_ram #(.WIDTH(TAG_W), .DEPTH(HEAP_WORDS)) u_tag_ram (
    .clk   (clk),
    .we    (acc_we && !acc_oor),
    .addr  (acc_addr[IW+1:2]),
    .wdata (acc_wd[TAG_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  addr_nxt = addr_r;  brk_nxt = brk_r;
    rover_nxt = rover_r;  init_nxt = init_r;  b_nxt = b_r;  bs_nxt = bs_r;
    pb_nxt = pb_r;  phs_nxt = phs_r;  pa_nxt = pa_r;  na_nxt = na_r;
    split_nxt = split_r;  ns_nxt = ns_r;  nf_nxt = nf_r;  msz_nxt = msz_r;
    wa1_nxt = wa1_r;  wa2_nxt = wa2_r;  need_nxt = need_r;  have_nxt = have_r;
    grow_nxt = grow_r;  steps_nxt = steps_r;  status_nxt = status_r;  res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;  out_addr_nxt = out_addr_r;
    chunk_nxt = cfg_wr_en ? cfg_wr_data : chunk_r;
    acc_addr = 32'd0;  acc_wd = 32'd0;  acc_we = 1'b0;  sz_sum = 32'd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_operation;
          addr_nxt = in_block_address;
          status_nxt = ST_OK;
          res_nxt = 16'd0;
          need_nxt = (in_request_bytes <= 16'd8) ? MIN_BLOCK
                   : ((32'(in_request_bytes) + 32'd15) & ~32'd7);
          state_nxt = S_FIN;
          if (in_operation == OP_INIT) begin
            brk_nxt = 32'd16;
            rover_nxt = PROLOGUE_PLD;
            init_nxt = 1'b1;
            state_nxt = S_INIT0;
          end else if (in_operation == OP_ALLOC) begin
            if (!init_r) begin
              status_nxt = ST_NOINIT;
            end else if (in_request_bytes == 16'd0) begin
              status_nxt = ST_ZERO;
            end else begin
              b_nxt = rover_r;
              steps_nxt = '0;
              state_nxt = S_SC0;
            end
          end else if (in_operation == OP_FREE) begin
            if (!init_r) begin
              status_nxt = ST_NOINIT;
            end else begin
              state_nxt = S_F0;
            end
          end
        end
      end
      // prologue and epilogue
      S_INIT0: begin
        acc_we = 1'b1;  acc_addr = 32'd0;  acc_wd = 32'd0;  state_nxt = S_INIT1;
      end
      S_INIT1: begin
        acc_we = 1'b1;  acc_addr = 32'd4;  acc_wd = 32'd9;  state_nxt = S_INIT2;
      end
      S_INIT2: begin
        acc_we = 1'b1;  acc_addr = 32'd8;  acc_wd = 32'd9;  state_nxt = S_INIT3;
      end
      S_INIT3: begin
        acc_we = 1'b1;  acc_addr = 32'd12;  acc_wd = 32'd1;
        grow_nxt = eff_chunk;
        state_nxt = S_GROW;
      end
      S_GROW: begin
        if (gsz > HB32 || brk_r > HB32 - gsz) begin
          status_nxt = ST_EXHAUST;
          state_nxt = S_FIN;
        end else begin
          acc_we = 1'b1;  acc_addr = brk_r - 32'd4;  acc_wd = gsz;
          brk_nxt = brk_r + gsz;
          b_nxt = brk_r;
          bs_nxt = gsz;
          state_nxt = S_GW1;
        end
      end
      S_GW1: begin
        acc_we = 1'b1;  acc_addr = b_r + bs_r - 32'd8;  acc_wd = bs_r;  state_nxt = S_GW2;
      end
      S_GW2: begin
        // new epilogue
        acc_we = 1'b1;  acc_addr = b_r + bs_r - 32'd4;  acc_wd = 32'd1;  state_nxt = S_M0;
      end
      // coalesce around b, whose size is bs
      S_M0: begin
        acc_addr = b_r - 32'd8;  state_nxt = S_M1;
      end
      S_M1: begin
        pb_nxt = b_r - rd_sz;
        acc_addr = b_r - rd_sz - 32'd4;
        state_nxt = S_M2;
      end
      S_M2: begin
        phs_nxt = rd_sz;
        acc_addr = pb_r + rd_sz - 32'd8;
        state_nxt = S_M3;
      end
      S_M3: begin
        pa_nxt = rd32[0];
        acc_addr = b_r + bs_r - 32'd4;
        state_nxt = S_M4;
      end
      S_M4: begin
        na_nxt = rd32[0];
        ns_nxt = rd_sz;
        acc_addr = b_r + bs_r + rd_sz - 32'd8;
        state_nxt = S_M5;
      end
      S_M5: begin
        nf_nxt = rd_sz;
        state_nxt = S_M6;
      end
      S_M6: begin
        state_nxt = S_MW1;
        priority if (pa_r && na_r) begin
          msz_nxt = bs_r;
          state_nxt = S_MDONE;
        end else if (pa_r) begin
          sz_sum = bs_r + ns_r;
          msz_nxt = sz_sum;
          wa1_nxt = b_r - 32'd4;
          wa2_nxt = b_r + sz_sum - 32'd8;
          rover_nxt = b_r;
        end else if (na_r) begin
          sz_sum = bs_r + phs_r;
          msz_nxt = sz_sum;
          wa1_nxt = b_r + bs_r - 32'd8;
          wa2_nxt = pb_r - 32'd4;
          rover_nxt = pb_r;
          b_nxt = pb_r;
        end else begin
          sz_sum = bs_r + phs_r + nf_r;
          msz_nxt = sz_sum;
          wa1_nxt = pb_r - 32'd4;
          wa2_nxt = b_r + bs_r + ns_r - 32'd8;
          rover_nxt = pb_r;
          b_nxt = pb_r;
        end
      end
      S_MW1: begin
        acc_we = 1'b1;  acc_addr = wa1_r;  acc_wd = msz_r;  state_nxt = S_MW2;
      end
      S_MW2: begin
        acc_we = 1'b1;  acc_addr = wa2_r;  acc_wd = msz_r;  state_nxt = S_MDONE;
      end
      S_MDONE: begin
        if (op_r == OP_ALLOC) begin
          have_nxt = 32'(msz_r[TAG_W-1:0]) & ~32'd7;
          state_nxt = S_SET;
        end else begin
          state_nxt = S_FIN;
        end
      end
      // next-fit walk, one header per cycle
      S_SC0: begin
        acc_addr = b_r - 32'd4;  state_nxt = S_SC1;
      end
      S_SC1: begin
        if (rd_sz == 32'd0 || b_r > brk_r || 32'(steps_r) > HW32) begin
          grow_nxt = (need_r > eff_chunk) ? need_r : eff_chunk;
          state_nxt = S_GROW;
        end else if (!rd32[0] && rd_sz >= need_r) begin
          have_nxt = rd_sz;
          state_nxt = S_SET;
        end else begin
          b_nxt = b_r + rd_sz;
          steps_nxt = steps_r + SW'(1);
          acc_addr = b_r + rd_sz - 32'd4;
        end
      end
      S_SET: begin
        split_nxt = (d_sz >= MIN_BLOCK);
        state_nxt = S_SW1;
      end
      S_SW1: begin
        acc_we = 1'b1;  acc_addr = b_r - 32'd4;
        acc_wd = split_r ? (need_r | 32'd1) : (have_r | 32'd1);
        state_nxt = S_SW2;
      end
      S_SW2: begin
        acc_we = 1'b1;
        acc_addr = split_r ? (b_r + need_r - 32'd8) : (b_r + have_r - 32'd8);
        acc_wd = split_r ? (need_r | 32'd1) : (have_r | 32'd1);
        state_nxt = split_r ? S_SW3 : S_FIN;
        if (!split_r) begin
          rover_nxt = b_r;
          res_nxt = b_r[15:0];
        end
      end
      S_SW3: begin
        // remainder header
        acc_we = 1'b1;  acc_addr = b_r + need_r - 32'd4;  acc_wd = d_sz;  state_nxt = S_SW4;
      end
      S_SW4: begin
        acc_we = 1'b1;  acc_addr = b_r + have_r - 32'd8;  acc_wd = d_sz;
        rover_nxt = b_r;
        res_nxt = b_r[15:0];
        state_nxt = S_FIN;
      end
      S_F0: begin
        acc_addr = 32'(addr_r) - 32'd4;  state_nxt = S_F1;
      end
      S_F1: begin
        acc_we = 1'b1;  acc_addr = 32'(addr_r) - 32'd4;  acc_wd = rd_sz;
        bs_nxt = rd_sz;
        b_nxt = 32'(addr_r);
        state_nxt = S_F2;
      end
      S_F2: begin
        acc_we = 1'b1;  acc_addr = b_r + bs_r - 32'd8;  acc_wd = bs_r;  state_nxt = S_M0;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      brk_r <= 32'd0;
      rover_r <= 32'd0;
      init_r <= 1'b0;
      chunk_r <= CHUNK_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      brk_r <= brk_nxt;
      rover_r <= rover_nxt;
      init_r <= init_nxt;
      chunk_r <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  addr_r <= addr_nxt;  b_r <= b_nxt;  bs_r <= bs_nxt;
    pb_r <= pb_nxt;  phs_r <= phs_nxt;  pa_r <= pa_nxt;  na_r <= na_nxt;
    split_r <= split_nxt;  ns_r <= ns_nxt;  nf_r <= nf_nxt;  msz_r <= msz_nxt;
    wa1_r <= wa1_nxt;  wa2_r <= wa2_nxt;  need_r <= need_nxt;  have_r <= have_nxt;
    grow_r <= grow_nxt;  steps_r <= steps_nxt;  status_r <= status_nxt;
    res_r <= res_nxt;  out_status_r <= out_status_nxt;  out_addr_r <= out_addr_nxt;
    rd_oor_r <= acc_oor;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ilnfa_checker.sv =====
`include "implicit_list_next_fit_allocator_unit_macros.svh"
`default_nettype none
module ilnfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_payload_address
);
  import ilnfa_pkg::*;

  `ILNFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_payload_address), "stalled result changed")
  `ILNFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted transaction did not occupy the sequencer")
  `ILNFA_ASSERT_NOW(a_addr_only_ok, out_valid && out_payload_address != 16'd0, out_status == ST_OK, "address returned with error status")

endmodule

bind implicit_list_next_fit_allocator_unit ilnfa_checker u_ilnfa_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import ilnfa_pkg::*;

  localparam int NWORDS = HEAP_WORDS_DEF;
  localparam logic [31:0] HEAP_SPAN = NWORDS * 4;

  // operation code with no function
  localparam logic [1:0] OP_NONE = 2'd3;

  // how a directed row picks the address it frees
  localparam logic [1:0] PICK_LIT = 2'd0;
  localparam logic [1:0] PICK_NEW = 2'd1;
  localparam logic [1:0] PICK_OLD = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } alloc_reply_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] req;
    logic [15:0] addr;
    logic [1:0]  pick;
    logic        fixed;
    logic [1:0]  status;
    logic [15:0] paddr;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_INIT;
  logic [15:0] in_request_bytes = '0;
  logic [15:0] in_block_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_payload_address;

  // predictor state
  logic [31:0] heap_tags [NWORDS];
  logic [31:0] heap_brk;
  logic [31:0] heap_rover;
  logic        heap_ready;
  logic [31:0] heap_chunk;

  alloc_reply_t reply_q[$];
  logic [15:0]  live_blocks[$];
  int           err_count = 0;
  bit           calm = 0;
  int           stall_left = 0;

  implicit_list_next_fit_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_request_bytes(in_request_bytes),
    .in_block_address(in_block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_payload_address(out_payload_address)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] tag_get(logic [31:0] a);
    logic [31:0] idx;
    idx = a >> 2;
    return (idx < NWORDS) ? heap_tags[idx] : 32'd0;
  endfunction

  function automatic void tag_put(logic [31:0] a, logic [31:0] v);
    logic [31:0] idx;
    idx = a >> 2;
    if (idx < NWORDS) heap_tags[idx] = v;
  endfunction

  function automatic logic [31:0] blk_size(logic [31:0] a);
    return tag_get(a) & ~32'd7;
  endfunction

  function automatic logic [31:0] blk_used(logic [31:0] a);
    return tag_get(a) & 32'd1;
  endfunction

  function automatic logic [31:0] next_blk(logic [31:0] b);
    return b + blk_size(b - 4);
  endfunction

  function automatic logic [31:0] prev_blk(logic [31:0] b);
    return b - blk_size(b - 8);
  endfunction

  function automatic logic [31:0] foot_of(logic [31:0] b);
    return b + blk_size(b - 4) - 8;
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] b);
    logic [31:0] pa, na, sz;
    pa = blk_used(foot_of(prev_blk(b)));
    na = blk_used(next_blk(b) - 4);
    sz = blk_size(b - 4);
    if (pa != 0 && na != 0) return b;
    if (pa != 0) begin
      sz += blk_size(next_blk(b) - 4);
      tag_put(b - 4, sz);
      tag_put(foot_of(b), sz);
    end else if (na != 0) begin
      sz += blk_size(prev_blk(b) - 4);
      tag_put(foot_of(b), sz);
      tag_put(prev_blk(b) - 4, sz);
      b = prev_blk(b);
    end else begin
      sz += blk_size(prev_blk(b) - 4) + blk_size(foot_of(next_blk(b)));
      tag_put(prev_blk(b) - 4, sz);
      tag_put(foot_of(next_blk(b)), sz);
      b = prev_blk(b);
    end
    heap_rover = b;
    return b;
  endfunction

  function automatic bit grow_heap(logic [31:0] bytes, output logic [31:0] blk);
    logic [31:0] sz, b;
    sz = (((bytes >> 2) + 1) & ~32'd1) * 4;
    b = heap_brk;
    blk = 0;
    if (sz > HEAP_SPAN || b > HEAP_SPAN - sz) return 0;
    heap_brk = b + sz;
    tag_put(b - 4, sz);
    tag_put(foot_of(b), sz);
    tag_put(next_blk(b) - 4, 32'd1);
    blk = coalesce(b);
    return 1;
  endfunction

  function automatic void carve(logic [31:0] b, logic [31:0] need);
    logic [31:0] have;
    have = blk_size(b - 4);
    if (have - need >= MIN_BLOCK) begin
      tag_put(b - 4, need | 1);
      tag_put(foot_of(b), need | 1);
      b = next_blk(b);
      tag_put(b - 4, have - need);
      tag_put(foot_of(b), have - need);
    end else begin
      tag_put(b - 4, have | 1);
      tag_put(foot_of(b), have | 1);
    end
  endfunction

  function automatic logic [31:0] grow_step();
    return (heap_chunk < 8) ? 32'd8 : heap_chunk;
  endfunction

  function automatic alloc_reply_t heap_apply(logic [1:0] op, logic [15:0] req,
                                              logic [15:0] addr);
    alloc_reply_t r;
    logic [31:0] blk, need, b, steps, sz, ext;
    bit found;
    r = '0;
    if (op == OP_INIT) begin
      heap_brk = 16;
      tag_put(0, 0);
      tag_put(4, 9);
      tag_put(8, 9);
      tag_put(12, 1);
      heap_rover = PROLOGUE_PLD;
      heap_ready = 1;
      if (!grow_heap(grow_step(), blk)) r.status = ST_EXHAUST;
    end else if (op == OP_ALLOC) begin
      if (!heap_ready) r.status = ST_NOINIT;
      else if (req == 0) r.status = ST_ZERO;
      else begin
        need = (req <= 8) ? MIN_BLOCK : ((32'(req) + 15) & ~32'd7);
        b = heap_rover;
        steps = 0;
        found = 0;
        while (blk_size(b - 4) > 0 && b <= heap_brk && steps <= NWORDS) begin
          if (blk_used(b - 4) == 0 && blk_size(b - 4) >= need) begin
            found = 1;
            break;
          end
          b = next_blk(b);
          steps++;
        end
        if (!found) begin
          ext = (need > grow_step()) ? need : grow_step();
          if (grow_heap(ext, blk)) begin
            b = blk;
            found = 1;
          end
        end
        if (found) begin
          carve(b, need);
          heap_rover = b;
          r.addr = b[15:0];
        end else r.status = ST_EXHAUST;
      end
    end else if (op == OP_FREE) begin
      if (!heap_ready) r.status = ST_NOINIT;
      else begin
        sz = blk_size(32'(addr) - 4);
        tag_put(32'(addr) - 4, sz);
        tag_put(foot_of(32'(addr)), sz);
        void'(coalesce(32'(addr)));
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected transaction status=%0d addr=%0d", $time,
                 out_status, out_payload_address);
        err_count++;
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          err_count++;
        end
        if (out_payload_address !== want.addr) begin
          $display("%0t: payload_address expected %0d actual %0d", $time, want.addr,
                   out_payload_address);
          err_count++;
        end
      end
    end
  end

  // hand one transaction to the block, predict it once accepted
  task automatic issue(logic [1:0] op, logic [15:0] req, logic [15:0] addr,
                       bit fixed, alloc_reply_t typed);
    int g;
    alloc_reply_t r;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_bytes <= req;
    in_block_address <= addr;
    do @(posedge clk); while (in_stall);
    r = heap_apply(op, req, addr);
    if (op == OP_INIT) live_blocks.delete();
    if (op == OP_ALLOC && r.status == ST_OK) live_blocks.push_back(r.addr);
    reply_q.push_back(fixed ? typed : r);
  endtask

  task automatic drain_and_set(logic [16:0] chunk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= chunk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    heap_chunk = 32'(chunk);
  endtask

  task automatic random_items(int n);
    int p, k;
    logic [15:0] req, a;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      if (k < 60) req = 16'($urandom_range(1, 64));
      else if (k < 85) req = 16'($urandom_range(1, 600));
      else if (k < 95) req = 16'($urandom_range(0, 8192));
      else req = 16'($urandom_range(0, 65535));
      if (p < 2) issue(OP_INIT, 16'($urandom), 16'($urandom), 1'b0, '0);
      else if (p < 5) issue(OP_NONE, 16'($urandom), 16'($urandom), 1'b0, '0);
      else if (p < 40 && (live_blocks.size() != 0 || !heap_ready)) begin
        if (!heap_ready) a = 16'($urandom);
        else begin
          k = $urandom_range(0, live_blocks.size() - 1);
          a = live_blocks[k];
          live_blocks.delete(k);
        end
        issue(OP_FREE, 16'($urandom), a, 1'b0, '0);
      end else issue(OP_ALLOC, req, 16'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    dir_row_t rows[20];
    logic [15:0] a;
    rows = '{
      '{OP_ALLOC, 16'd5, 16'd0, PICK_LIT, 1'b1, ST_NOINIT, 16'd0},
      '{OP_FREE, 16'd0, 16'h1234, PICK_LIT, 1'b1, ST_NOINIT, 16'd0},
      '{OP_NONE, 16'hFFFF, 16'hFFFF, PICK_LIT, 1'b1, ST_OK, 16'd0},
      '{OP_INIT, 16'd0, 16'd0, PICK_LIT, 1'b1, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd0, 16'd0, PICK_LIT, 1'b1, ST_ZERO, 16'd0},
      '{OP_ALLOC, 16'd1, 16'd0, PICK_LIT, 1'b1, ST_OK, 16'd16},
      '{OP_ALLOC, 16'd8, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd9, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_ALLOC, 16'hFFFF, 16'd0, PICK_LIT, 1'b1, ST_EXHAUST, 16'd0},
      '{OP_ALLOC, 16'd4000, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_FREE, 16'd0, 16'd0, PICK_NEW, 1'b1, ST_OK, 16'd0},
      '{OP_FREE, 16'd0, 16'd0, PICK_OLD, 1'b1, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd24, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd16, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_FREE, 16'd0, 16'd0, PICK_NEW, 1'b1, ST_OK, 16'd0},
      '{OP_FREE, 16'd0, 16'd0, PICK_NEW, 1'b1, ST_OK, 16'd0},
      '{OP_INIT, 16'd0, 16'd0, PICK_LIT, 1'b1, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd4080, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_ALLOC, 16'd1, 16'd0, PICK_LIT, 1'b0, ST_OK, 16'd0},
      '{OP_NONE, 16'd0, 16'd0, PICK_LIT, 1'b1, ST_OK, 16'd0}
    };
    for (int i = 0; i < NWORDS; i++) heap_tags[i] = 0;
    heap_brk = 0;
    heap_rover = 0;
    heap_ready = 0;
    heap_chunk = 32'(CHUNK_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      a = rows[i].addr;
      if (rows[i].pick == PICK_NEW && live_blocks.size() != 0) a = live_blocks.pop_back();
      if (rows[i].pick == PICK_OLD && live_blocks.size() != 0) a = live_blocks.pop_front();
      issue(rows[i].op, rows[i].req, a, rows[i].fixed, {rows[i].status, rows[i].paddr});
    end
    random_items(140);

    // smallest growth step, calm stretch with no idling
    drain_and_set(17'd8);
    calm = 1;
    issue(OP_INIT, 16'd0, 16'd0, 1'b0, '0);
    random_items(120);
    calm = 0;

    // below the minimum, handled as eight bytes
    drain_and_set(17'd0);
    issue(OP_INIT, 16'd0, 16'd0, 1'b0, '0);
    random_items(90);

    // whole heap as one chunk: first growth cannot fit
    drain_and_set(17'd65536);
    issue(OP_INIT, 16'd0, 16'd0, 1'b1, {ST_EXHAUST, 16'd0});
    random_items(25);

    drain_and_set(17'd100);
    issue(OP_INIT, 16'd0, 16'd0, 1'b0, '0);
    random_items(140);

    drain_and_set(17'd1024);
    issue(OP_INIT, 16'd0, 16'd0, 1'b0, '0);
    random_items(140);

    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #150000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
